// ===== src/smooth_damp_follower_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Smooth damp follower assertion macros
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SMOOTH_DAMP_FOLLOWER_UNIT_DEFINES_SVH
`define SMOOTH_DAMP_FOLLOWER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Smooth damp follower package
// Widths, constants, operation codes and control structures.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned DT_W   = 17;
    localparam int unsigned ST_W   = 23;
    localparam int unsigned AXIS_N = 3;
    localparam int unsigned AXIS_W = 2;

    localparam int unsigned MA_W = 49;
    localparam int unsigned MB_W = 33;
    localparam int unsigned MP_W = MA_W + MB_W;

    localparam int unsigned DN_W = 49;
    localparam int unsigned DD_W = 40;

    localparam logic [DT_W-1:0] DT_MAX     = 17'd65536;
    localparam logic [ST_W-1:0] MIN_SMOOTH = 23'd7;
    localparam logic [ST_W-1:0] ST_RESET   = 23'd65536;
    localparam logic [24:0]     X_MAX      = 25'd16777216;
    localparam logic [MB_W-1:0] C048       = 33'd31457;
    localparam logic [MB_W-1:0] C0235      = 33'd15401;

    typedef enum logic [3:0] {
        OP_NONE, OP_OMEGA, OP_X, OP_X2, OP_X3, OP_T1, OP_T2, OP_E,
        OP_M1, OP_TEMP, OP_M2, OP_NV, OP_RES, OP_OVS
    } t_op;

    typedef struct packed {
        logic              capture;
        logic              start;
        t_op               op;
        logic [AXIS_W-1:0] axis;
        logic              load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_status;

endpackage

// ===== src/smooth_damp_follower_unit.sv =====
// ----------------------------------------------------------------------------
// Smooth damp follower unit
// Critically damped spring follower for up to three axes in signed Q16.16.
// ----------------------------------------------------------------------------
// The input channel transfers current and target positions and a step time.
// The output channel transfers the smoothed position and the snap flag.
// The configuration channel writes the smoothing time and is always ready.
// One item is worked on at a time by a bit-serial multiplier and a
// bit-serial divider under a sequencer.
// The input is ready again in the cycle after the result is registered.
// If the receiver stalls, the result waits in the output register and the
// next item may already be taken; its own result waits until the output
// register is free. Reset clears the velocity of every axis, sets the
// smoothing time to 1.0 s and empties the output register.
// ----------------------------------------------------------------------------
module smooth_damp_follower_unit #(
    parameter int unsigned AXES = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_current_x,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_current_y,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_current_z,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_target_x,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_target_y,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_target_z,
    input  logic [sdf_pkg::DT_W-1:0]          i_step_time,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [sdf_pkg::POS_W-1:0]  o_out_x,
    output logic signed [sdf_pkg::POS_W-1:0]  o_out_y,
    output logic signed [sdf_pkg::POS_W-1:0]  o_out_z,
    output logic                              o_snapped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sdf_pkg::ST_W-1:0]          i_cfg_smooth_time
);
    import sdf_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sdf_ctrl #(
        .AXES (AXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sdf_datapath #(
        .AXES (AXES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_smooth_time),
        .i_current_x (i_current_x),
        .i_current_y (i_current_y),
        .i_current_z (i_current_z),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .i_target_z  (i_target_z),
        .i_step_time (i_step_time),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_snapped   (o_snapped)
    );

endmodule

// ===== src/sdf_mul.sv =====
// ----------------------------------------------------------------------------
// Smooth damp follower serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sdf_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sdf_pkg::MA_W-1:0]  i_a,
    input  logic [sdf_pkg::MB_W-1:0]  i_b,
    output logic                      o_done,
    output logic [sdf_pkg::MP_W-1:0]  o_p
);
    import sdf_pkg::*;

    localparam int unsigned CNT_W = $clog2(MB_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MB_W - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [MP_W-1:0]  r_a;
    logic [MB_W-1:0]  r_b;
    logic [MP_W-1:0]  r_acc;
    logic [MP_W-1:0]  n_acc;

    assign n_acc  = r_acc + (r_b[0] ? r_a : '0);
    assign o_p    = n_acc;
    assign o_done = r_busy && (r_cnt == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_a   <= MP_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_acc <= n_acc;
        end
    end

endmodule

// ===== src/sdf_div.sv =====
// ----------------------------------------------------------------------------
// Smooth damp follower serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sdf_pkg::DN_W-1:0]  i_num,
    input  logic [sdf_pkg::DD_W-1:0]  i_den,
    output logic                      o_done,
    output logic [sdf_pkg::DN_W-1:0]  o_q
);
    import sdf_pkg::*;

    localparam int unsigned CNT_W = $clog2(DN_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DN_W - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DD_W-1:0]  r_rem;
    logic [DD_W-1:0]  r_d;
    logic [DN_W-1:0]  r_num;
    logic [DN_W-1:0]  r_q;
    logic [DD_W:0]    sh;
    logic             qbit;
    logic [DD_W-1:0]  n_rem;

    always_comb begin
        sh    = {r_rem, r_num[DN_W-1]};
        qbit  = (sh >= {1'b0, r_d});
        n_rem = qbit ? DD_W'(sh - {1'b0, r_d}) : sh[DD_W-1:0];
    end

    assign o_q    = {r_q[DN_W-2:0], qbit};
    assign o_done = r_busy && (r_cnt == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_d   <= i_den;
            r_num <= i_num;
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_num <= r_num << 1;
            r_q   <= o_q;
        end
    end

endmodule

// ===== src/sdf_datapath.sv =====
// ----------------------------------------------------------------------------
// Smooth damp follower datapath
// Operand registers, shared multiplier and divider, result write-back.
// ----------------------------------------------------------------------------
module sdf_datapath #(
    parameter int unsigned AXES = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdf_pkg::t_cmd                     i_cmd,
    output sdf_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [sdf_pkg::ST_W-1:0]          i_cfg_data,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_current_x,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_current_y,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_current_z,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_target_x,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_target_y,
    input  logic signed [sdf_pkg::POS_W-1:0]  i_target_z,
    input  logic [sdf_pkg::DT_W-1:0]          i_step_time,
    output logic signed [sdf_pkg::POS_W-1:0]  o_out_x,
    output logic signed [sdf_pkg::POS_W-1:0]  o_out_y,
    output logic signed [sdf_pkg::POS_W-1:0]  o_out_z,
    output logic                              o_snapped
);
    import sdf_pkg::*;

    logic [ST_W-1:0]          r_smooth_time;
    logic signed [POS_W-1:0]  r_cur [AXIS_N];
    logic signed [POS_W-1:0]  r_tgt [AXIS_N];
    logic signed [POS_W-1:0]  r_vel [AXIS_N];
    logic signed [POS_W-1:0]  r_res [AXIS_N];
    logic signed [POS_W-1:0]  r_nv  [AXIS_N];
    logic signed [POS_W-1:0]  in_cur [AXIS_N];
    logic signed [POS_W-1:0]  in_tgt [AXIS_N];
    logic signed [POS_W-1:0]  r_out [AXIS_N];
    logic                     r_snapped;
    logic [DT_W-1:0]          r_dt;
    logic [30:0]              r_omega;
    logic [24:0]              r_x;
    logic [32:0]              r_x2;
    logic [40:0]              r_x3;
    logic [38:0]              r_den;
    logic [32:0]              r_e;
    logic signed [49:0]       r_s;
    logic signed [47:0]       r_temp;
    logic signed [67:0]       r_acc;

    logic signed [POS_W-1:0]  cur_a;
    logic signed [POS_W-1:0]  tgt_a;
    logic signed [POS_W-1:0]  vel_a;
    logic signed [32:0]       change;
    logic signed [32:0]       f2;
    logic signed [49:0]       a_val;
    logic [MB_W-1:0]          b_val;
    logic                     b_neg;
    logic [49:0]              a_abs;
    logic                     neg;
    logic                     is_div;
    logic                     mul_done;
    logic                     div_done;
    logic [MP_W-1:0]          prod;
    logic [DN_W-1:0]          quot;
    logic [DN_W-1:0]          div_num;
    logic [DD_W-1:0]          div_den;
    logic [ST_W-1:0]          st_c;
    logic [MP_W-1:0]          sh16;
    logic [MP_W-1:0]          sh32;
    logic signed [49:0]       sgn16;
    logic signed [49:0]       sgn32;
    logic signed [67:0]       prod_s;
    logic                     snap;

    function automatic logic [46:0] sat47(input logic [MP_W-1:0] m);
        sat47 = (|m[MP_W-1:47]) ? '1 : m[46:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [49:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    assign in_cur[0] = i_current_x;
    assign in_cur[1] = i_current_y;
    assign in_cur[2] = i_current_z;
    assign in_tgt[0] = i_target_x;
    assign in_tgt[1] = i_target_y;
    assign in_tgt[2] = i_target_z;

    always_comb begin
        cur_a  = r_cur[i_cmd.axis];
        tgt_a  = r_tgt[i_cmd.axis];
        vel_a  = r_vel[i_cmd.axis];
        change = {cur_a[POS_W-1], cur_a} - {tgt_a[POS_W-1], tgt_a};
        f2     = {r_res[i_cmd.axis][POS_W-1], r_res[i_cmd.axis]} - {tgt_a[POS_W-1], tgt_a};
        a_val  = '0;
        b_val  = '0;
        b_neg  = 1'b0;
        is_div = 1'b0;
        case (i_cmd.op)
            OP_OMEGA: is_div = 1'b1;
            OP_E:     is_div = 1'b1;
            OP_X: begin
                a_val = 50'(r_omega);
                b_val = MB_W'(r_dt);
            end
            OP_X2: begin
                a_val = 50'(r_x);
                b_val = MB_W'(r_x);
            end
            OP_X3: begin
                a_val = 50'(r_x2);
                b_val = MB_W'(r_x);
            end
            OP_T1: begin
                a_val = 50'(r_x2);
                b_val = C048;
            end
            OP_T2: begin
                a_val = 50'(r_x3);
                b_val = C0235;
            end
            OP_M1: begin
                a_val = 50'(change);
                b_val = MB_W'(r_omega);
            end
            OP_TEMP: begin
                a_val = r_s;
                b_val = MB_W'(r_dt);
            end
            OP_M2: begin
                a_val = 50'(r_temp);
                b_val = MB_W'(r_omega);
            end
            OP_NV: begin
                a_val = r_s;
                b_val = r_e;
            end
            OP_RES: begin
                a_val = 50'(change) + 50'(r_temp);
                b_val = r_e;
            end
            OP_OVS: begin
                a_val = -50'(change);
                b_val = f2[32] ? MB_W'(-f2) : MB_W'(f2);
                b_neg = f2[32];
            end
            default: begin
                a_val = '0;
            end
        endcase
        a_abs = a_val[49] ? 50'(-a_val) : 50'(a_val);
        neg   = a_val[49] ^ b_neg;
    end

    always_comb begin
        st_c    = (r_smooth_time < MIN_SMOOTH) ? MIN_SMOOTH : r_smooth_time;
        div_num = (i_cmd.op == OP_OMEGA) ? (DN_W'(1) << 33) : (DN_W'(1) << 48);
        div_den = (i_cmd.op == OP_OMEGA) ? DD_W'(st_c) : DD_W'(r_den);
    end

    sdf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && !is_div),
        .i_a     (a_abs[MA_W-1:0]),
        .i_b     (b_val),
        .o_done  (mul_done),
        .o_p     (prod)
    );

    sdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && is_div),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (quot)
    );

    assign o_status.mul_done = mul_done;
    assign o_status.div_done = div_done;

    always_comb begin
        sh16   = prod >> 16;
        sh32   = prod >> 32;
        sgn16  = neg ? -$signed({3'b000, sat47(sh16)}) : $signed({3'b000, sat47(sh16)});
        sgn32  = neg ? -$signed({3'b000, sat47(sh32)}) : $signed({3'b000, sat47(sh32)});
        prod_s = neg ? -$signed({1'b0, prod[66:0]}) : $signed({1'b0, prod[66:0]});
        snap   = !r_acc[67] && (|r_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_time <= ST_RESET;
            for (int i = 0; i < AXIS_N; i++) begin
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_smooth_time <= i_cfg_data;
            end
            if (i_cmd.load) begin
                for (int i = 0; i < AXIS_N; i++) begin
                    r_vel[i] <= snap ? '0 : r_nv[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < AXIS_N; i++) begin
                r_cur[i] <= (i < AXES) ? in_cur[i] : '0;
                r_tgt[i] <= (i < AXES) ? in_tgt[i] : '0;
                r_res[i] <= '0;
                r_nv[i]  <= '0;
            end
            r_dt  <= (i_step_time > DT_MAX) ? DT_MAX : i_step_time;
            r_acc <= '0;
        end
        if (i_cmd.load) begin
            for (int i = 0; i < AXIS_N; i++) begin
                r_out[i] <= snap ? r_tgt[i] : r_res[i];
            end
            r_snapped <= snap;
        end
        if (div_done) begin
            if (i_cmd.op == OP_OMEGA) begin
                r_omega <= quot[30:0];
            end else begin
                r_e <= quot[32:0];
            end
        end
        if (mul_done) begin
            case (i_cmd.op)
                OP_X:    r_x <= (sh16 > MP_W'(X_MAX)) ? X_MAX : sh16[24:0];
                OP_X2:   r_x2 <= sh16[32:0];
                OP_X3:   r_x3 <= sh16[40:0];
                OP_T1:   r_den <= 39'd65536 + 39'(r_x) + sh16[38:0];
                OP_T2:   r_den <= r_den + sh16[38:0];
                OP_M1:   r_s <= 50'(vel_a) + sgn16;
                OP_TEMP: r_temp <= sgn16[47:0];
                OP_M2:   r_s <= 50'(vel_a) - sgn16;
                OP_NV:   r_nv[i_cmd.axis] <= sat32(sgn32);
                OP_RES:  r_res[i_cmd.axis] <= sat32(50'(tgt_a) + sgn32);
                OP_OVS:  r_acc <= r_acc + prod_s;
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_out_x   = r_out[0];
    assign o_out_y   = r_out[1];
    assign o_out_z   = r_out[2];
    assign o_snapped = r_snapped;

endmodule

// ===== src/sdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Smooth damp follower controller
// Sequences the operations of one item and runs both handshakes.
// ----------------------------------------------------------------------------
module sdf_ctrl #(
    parameter int unsigned AXES = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sdf_pkg::t_status  i_status,
    output sdf_pkg::t_cmd     o_cmd
);
    import sdf_pkg::*;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_OMEGA, S_X, S_X2, S_X3, S_T1, S_T2, S_E,
        S_M1, S_TEMP, S_M2, S_NV, S_RES, S_OVS, S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic              r_issued, n_issued;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic              r_out_valid, n_out_valid;
    t_op               op;
    logic              done;

    always_comb begin
        case (r_state)
            S_OMEGA: op = OP_OMEGA;
            S_X:     op = OP_X;
            S_X2:    op = OP_X2;
            S_X3:    op = OP_X3;
            S_T1:    op = OP_T1;
            S_T2:    op = OP_T2;
            S_E:     op = OP_E;
            S_M1:    op = OP_M1;
            S_TEMP:  op = OP_TEMP;
            S_M2:    op = OP_M2;
            S_NV:    op = OP_NV;
            S_RES:   op = OP_RES;
            S_OVS:   op = OP_OVS;
            default: op = OP_NONE;
        endcase
    end

    assign done = r_issued && (i_status.mul_done || i_status.div_done);

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.start   = (op != OP_NONE) && !r_issued;
        o_cmd.op      = op;
        o_cmd.axis    = r_axis;
        o_cmd.load    = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.start) begin
            n_issued = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_OMEGA;
                    n_axis  = '0;
                end
            end
            S_FIN: begin
                if (o_cmd.load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                if (done) begin
                    n_issued = 1'b0;
                    case (r_state)
                        S_OMEGA: n_state = S_X;
                        S_X:     n_state = S_X2;
                        S_X2:    n_state = S_X3;
                        S_X3:    n_state = S_T1;
                        S_T1:    n_state = S_T2;
                        S_T2:    n_state = S_E;
                        S_E:     n_state = S_M1;
                        S_M1:    n_state = S_TEMP;
                        S_TEMP:  n_state = S_M2;
                        S_M2:    n_state = S_NV;
                        S_NV:    n_state = S_RES;
                        S_RES:   n_state = S_OVS;
                        S_OVS: begin
                            if (r_axis == LAST_AXIS) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_M1;
                                n_axis  = r_axis + 1'b1;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/sdf_checker.sv =====
// ----------------------------------------------------------------------------
// Smooth damp follower port checker
// Checks the port behavior of the follower over time.
// ----------------------------------------------------------------------------
`include "smooth_damp_follower_unit_defines.svh"

module sdf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic signed [sdf_pkg::POS_W-1:0]  i_current_x,
    input logic signed [sdf_pkg::POS_W-1:0]  i_current_y,
    input logic signed [sdf_pkg::POS_W-1:0]  i_current_z,
    input logic signed [sdf_pkg::POS_W-1:0]  i_target_x,
    input logic signed [sdf_pkg::POS_W-1:0]  i_target_y,
    input logic signed [sdf_pkg::POS_W-1:0]  i_target_z,
    input logic [sdf_pkg::DT_W-1:0]          i_step_time,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [sdf_pkg::POS_W-1:0]  o_out_x,
    input logic signed [sdf_pkg::POS_W-1:0]  o_out_y,
    input logic signed [sdf_pkg::POS_W-1:0]  o_out_z,
    input logic                              o_snapped,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [sdf_pkg::ST_W-1:0]          i_cfg_smooth_time
);

    `SDF_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "input ready after a transfer")

    `SDF_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid),
        !$past(o_in_ready), "result appeared without work in progress")

    `SDF_ASSERT_NXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "output valid dropped while stalled")

    `SDF_ASSERT_NXT(a_out_data_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_snapped),
        "output payload changed while stalled")

    `SDF_ASSERT_IMP(a_cfg_always_ready, i_clk, i_rst_n, i_cfg_valid,
        o_cfg_ready, "configuration write not taken")

endmodule

bind smooth_damp_follower_unit sdf_checker u_sdf_checker (.*);
